[rtl/core/km2d_pkg.sv]
// Package for the 2D k-means block: widths, opcodes, status codes, shared types.
// No dependencies.
package km2d_pkg;

    localparam int MaxPoints   = 1024;
    localparam int MaxClusters = 16;
    localparam int CoordW      = 16;
    localparam int PtAw        = $clog2(MaxPoints);
    localparam int ClAw        = $clog2(MaxClusters);
    localparam int SumW        = CoordW + PtAw;
    localparam int CntW        = PtAw + 1;
    localparam int DistW       = 2 * CoordW + 2;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_RUN   = 2'd1;
    localparam logic [1:0] OP_RDCEN = 2'd2;
    localparam logic [1:0] OP_RDASG = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_COUNT = 2'd2;

    localparam logic [1:0] REG_NPTS = 2'd0;
    localparam logic [1:0] REG_NCL  = 2'd1;
    localparam logic [1:0] REG_ITER = 2'd2;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [9:0]        index;
        logic signed [15:0] point_x;
        logic signed [15:0] point_y;
    } req_t;

    typedef struct packed {
        logic signed [15:0] out_x;
        logic signed [15:0] out_y;
        logic [3:0]         out_cluster;
        logic [15:0]        out_rounds;
        logic               out_converged;
        logic [1:0]         status;
    } rsp_t;

    // Control handed from the sequencer to the divider.
    typedef struct packed {
        logic              start;
        logic signed [SumW-1:0] dividend;
        logic [CntW-1:0]   divisor;
    } div_req_t;

endpackage

[rtl/core/km2d_if.sv]
// Valid/ready channel carrying one word of type T.
// No dependencies.
interface km2d_if #(parameter type T = logic) (input logic clk);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/kmeans_clustering_2d.sv]
// 2D k-means top level. A run repeats an assignment pass over all points and clusters,
// then divides the sums of each non-empty cluster in the serial divider; the
// assignment passes set the pace.
// After rst_n rises, a pass clears every entry of the assignment memory; no word is
// taken until it ends. Centroids and accumulators reset to zero; points are undefined.
// One word in flight: the next word is taken once the result has been taken.
module kmeans_clustering_2d (
    input  logic        clk,
    input  logic        rst_n,
    km2d_if.sink        in_ch,
    km2d_if.source      out_ch,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import km2d_pkg::*;

    logic [10:0] npts_reg;
    logic [4:0]  ncl_reg;
    logic [15:0] iter_reg;
    logic        busy_reg, ovalid_reg;
    rsp_t        odata_reg;
    logic        go, done;
    logic        clearing;
    rsp_t        rsp;

    // Config registers; the user must write them only while idle, the block does not enforce it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            npts_reg <= 11'd1;
            ncl_reg  <= 5'd1;
            iter_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_NPTS: npts_reg <= cfg_data[10:0];
                REG_NCL:  ncl_reg  <= cfg_data[4:0];
                REG_ITER: iter_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Hold off input while busy, while a result waits, and during the clear pass.
    assign in_ch.ready = !busy_reg && !ovalid_reg && !clearing;
    assign go = in_ch.valid && in_ch.ready;

    km2d_core u_core (
        .clk(clk), .rst_n(rst_n), .go(go), .req(in_ch.data),
        .num_points(npts_reg), .num_clusters(ncl_reg), .max_iterations(iter_reg),
        .done(done), .clearing(clearing), .rsp(rsp)
    );

    // Output register holds the word until the sink takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
            odata_reg  <= '0;
        end
        else
        begin
            if (go) busy_reg <= 1'b1;
            if (done)
            begin
                busy_reg   <= 1'b0;
                ovalid_reg <= 1'b1;
                odata_reg  <= rsp;
            end
            else if (out_ch.ready) ovalid_reg <= 1'b0;
        end
    end

    assign out_ch.valid = ovalid_reg;
    assign out_ch.data  = odata_reg;
endmodule

[rtl/core/km2d_div.sv]
// Restoring signed divider, one quotient bit per cycle, truncates toward zero.
// Depends on km2d_pkg.
module km2d_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  km2d_pkg::div_req_t   req,
    output logic                 done,
    output logic signed [km2d_pkg::SumW-1:0] quot
);
    import km2d_pkg::*;

    logic [SumW-1:0]  mag_reg, mag_next;
    logic [CntW:0]    rem_reg, rem_next;
    logic [CntW-1:0]  den_reg, den_next;
    logic             neg_reg, neg_next;
    logic [$clog2(SumW+1)-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [CntW:0]    trial;
    logic [SumW-1:0]  step_mag;
    logic [CntW:0]    step_rem;

    // One restoring step; on the last step this is the final magnitude.
    always_comb
    begin
        trial = {rem_reg[CntW-1:0], mag_reg[SumW-1]};
        if (trial >= {1'b0, den_reg})
        begin
            step_rem = trial - {1'b0, den_reg};
            step_mag = {mag_reg[SumW-2:0], 1'b1};
        end
        else
        begin
            step_rem = trial;
            step_mag = {mag_reg[SumW-2:0], 1'b0};
        end
    end

    always_comb
    begin
        mag_next  = mag_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (req.start)
        begin
            neg_next  = req.dividend[SumW-1];
            mag_next  = req.dividend[SumW-1] ? SumW'(-req.dividend) : req.dividend;
            rem_next  = '0;
            den_next  = req.divisor;
            cnt_next  = ($clog2(SumW+1))'(SumW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = step_rem;
            mag_next = step_mag;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == 1) busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    // Quotient is valid in the cycle done is high, even if a new start follows.
    assign done = busy_reg && (cnt_reg == 1);
    assign quot = neg_reg ? SumW'(-step_mag) : step_mag;
endmodule

[rtl/core/km2d_core.sv]
// Sequencer, point/assignment memories, centroid and accumulator files.
// Depends on km2d_pkg and km2d_div.
module km2d_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  go,
    input  km2d_pkg::req_t        req,
    input  logic [10:0]           num_points,
    input  logic [4:0]            num_clusters,
    input  logic [15:0]           max_iterations,
    output logic                  done,
    output logic                  clearing,
    output km2d_pkg::rsp_t        rsp
);
    import km2d_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_SEED_RD, S_SEED_WR, S_CLR, S_ARD, S_ADIST, S_ACMP, S_AWB,
        S_ACHK, S_DIVX, S_DIVY, S_DNEXT, S_RDOUT, S_FIN
    } state_t;

    // Point memory: x and y packed; assignment memory cleared by a pass.
    logic [2*CoordW-1:0] pt_mem [MaxPoints];
    logic [ClAw-1:0]     asg_mem [MaxPoints];
    logic [2*CoordW-1:0] pt_rd;
    logic [ClAw-1:0]     asg_rd;
    logic [PtAw-1:0]     pt_addr, asg_addr;
    logic                asg_we;
    logic [ClAw-1:0]     asg_wd;

    logic signed [CoordW-1:0] cx_reg [MaxClusters];
    logic signed [CoordW-1:0] cy_reg [MaxClusters];
    logic signed [SumW-1:0]   sx_reg [MaxClusters];
    logic signed [SumW-1:0]   sy_reg [MaxClusters];
    logic [CntW-1:0]          mc_reg [MaxClusters];

    state_t           state_reg;
    logic [PtAw:0]    pi_reg;
    logic [ClAw:0]    ci_reg;
    logic [ClAw-1:0]  best_reg;
    logic [DistW-1:0] bestd_reg, d_reg;
    logic [10:0]      chg_reg;
    logic [15:0]      iters_reg, rounds_reg, rdone_reg;
    logic             conv_reg;
    logic             clr_reg;
    logic [PtAw:0]    clr_idx_reg;
    logic [10:0]      n_reg;
    logic [4:0]       k_reg;
    req_t             q_reg;
    rsp_t             rsp_reg;
    logic             done_reg;

    logic signed [CoordW:0]   dx, dy;
    logic [CoordW:0]          ax, ay;
    logic [2*CoordW+1:0]      d_next;
    div_req_t                 dreq;
    logic                     ddone;
    logic signed [SumW-1:0]   dq;
    logic signed [CoordW-1:0] px, py;

    assign px = pt_rd[2*CoordW-1:CoordW];
    assign py = pt_rd[CoordW-1:0];
    assign dx = {px[CoordW-1], px} - {cx_reg[ci_reg[ClAw-1:0]][CoordW-1], cx_reg[ci_reg[ClAw-1:0]]};
    assign dy = {py[CoordW-1], py} - {cy_reg[ci_reg[ClAw-1:0]][CoordW-1], cy_reg[ci_reg[ClAw-1:0]]};
    assign ax = dx[CoordW] ? (CoordW+1)'(-dx) : dx;
    assign ay = dy[CoordW] ? (CoordW+1)'(-dy) : dy;
    assign d_next = (2*CoordW+2)'(ax * ax) + (2*CoordW+2)'(ay * ay);

    km2d_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .done(ddone), .quot(dq));

    always_comb
    begin
        dreq.start    = 1'b0;
        dreq.dividend = sx_reg[ci_reg[ClAw-1:0]];
        dreq.divisor  = mc_reg[ci_reg[ClAw-1:0]];
        if ((state_reg == S_DNEXT) && (ci_reg < k_reg)
            && mc_reg[ci_reg[ClAw-1:0]] != 0)
            dreq.start = 1'b1;
        else if (state_reg == S_DIVX && ddone)
        begin
            dreq.start    = 1'b1;
            dreq.dividend = sy_reg[ci_reg[ClAw-1:0]];
        end
    end

    always_comb
    begin
        pt_addr  = pi_reg[PtAw-1:0];
        asg_addr = clr_reg ? clr_idx_reg[PtAw-1:0] : pi_reg[PtAw-1:0];
        asg_we   = clr_reg || (state_reg == S_AWB);
        asg_wd   = clr_reg ? '0 : best_reg;
        if (state_reg == S_IDLE)
        begin
            pt_addr  = q_reg.index;
            if (!clr_reg) asg_addr = q_reg.index;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go && req.opcode == OP_WRITE)
            pt_mem[req.index] <= {req.point_x, req.point_y};
        pt_rd <= pt_mem[go ? req.index : pt_addr];
        if (asg_we)
            asg_mem[asg_addr] <= asg_wd;
        asg_rd <= asg_mem[go ? req.index : asg_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            clr_reg     <= 1'b1;
            clr_idx_reg <= '0;
            done_reg    <= 1'b0;
            rdone_reg   <= '0;
            conv_reg    <= 1'b0;
            for (int i = 0; i < MaxClusters; i++)
            begin
                cx_reg[i] <= '0;
                cy_reg[i] <= '0;
                sx_reg[i] <= '0;
                sy_reg[i] <= '0;
                mc_reg[i] <= '0;
            end
            pi_reg <= '0; ci_reg <= '0; best_reg <= '0; bestd_reg <= '0; d_reg <= '0;
            chg_reg <= '0; iters_reg <= '0; rounds_reg <= '0; n_reg <= '0; k_reg <= '0;
            q_reg <= '0; rsp_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (clr_reg)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
                if (clr_idx_reg == (PtAw+1)'(MaxPoints - 1)) clr_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (go)
                    begin
                        q_reg <= req;
                        rsp_reg <= '0;
                        n_reg <= num_points;
                        k_reg <= num_clusters;
                        iters_reg <= max_iterations;
                        if (req.opcode == OP_RUN)
                        begin
                            if (num_clusters == 0 || num_clusters > 5'(MaxClusters))
                            begin
                                rsp_reg.status <= ST_COUNT; state_reg <= S_FIN;
                            end
                            else if (num_points > 11'(MaxPoints))
                            begin
                                rsp_reg.status <= ST_RANGE; state_reg <= S_FIN;
                            end
                            else if ({6'd0, num_clusters} > num_points)
                            begin
                                rsp_reg.status <= ST_COUNT; state_reg <= S_FIN;
                            end
                            else
                            begin
                                pi_reg <= '0; rounds_reg <= '0; state_reg <= S_SEED_RD;
                            end
                        end
                        else
                            state_reg <= S_RDOUT;
                    end
                end
                S_SEED_RD: state_reg <= S_SEED_WR;
                S_SEED_WR:
                begin
                    cx_reg[pi_reg[ClAw-1:0]] <= px;
                    cy_reg[pi_reg[ClAw-1:0]] <= py;
                    if (pi_reg + 1'b1 == {6'd0, k_reg}) state_reg <= S_CLR;
                    else state_reg <= S_SEED_RD;
                    pi_reg <= pi_reg + 1'b1;
                end
                S_CLR:
                begin
                    for (int i = 0; i < MaxClusters; i++)
                    begin
                        sx_reg[i] <= '0; sy_reg[i] <= '0; mc_reg[i] <= '0;
                    end
                    chg_reg <= '0; pi_reg <= '0;
                    state_reg <= clr_reg ? S_CLR : S_ARD;
                end
                S_ARD:
                begin
                    ci_reg <= '0; state_reg <= S_ADIST;
                end
                S_ADIST:
                begin
                    d_reg <= d_next;
                    state_reg <= S_ACMP;
                end
                S_ACMP:
                begin
                    if (ci_reg == 0 || d_reg < bestd_reg)
                    begin
                        bestd_reg <= d_reg; best_reg <= ci_reg[ClAw-1:0];
                    end
                    if (ci_reg + 1'b1 == k_reg) state_reg <= S_AWB;
                    else
                    begin
                        ci_reg <= ci_reg + 1'b1; state_reg <= S_ADIST;
                    end
                end
                S_AWB:
                begin
                    if (asg_rd != best_reg) chg_reg <= chg_reg + 1'b1;
                    sx_reg[best_reg] <= sx_reg[best_reg] + SumW'(px);
                    sy_reg[best_reg] <= sy_reg[best_reg] + SumW'(py);
                    mc_reg[best_reg] <= mc_reg[best_reg] + 1'b1;
                    pi_reg <= pi_reg + 1'b1;
                    state_reg <= (pi_reg + 1'b1 == n_reg) ? S_ACHK : S_ARD;
                end
                S_ACHK:
                begin
                    ci_reg <= '0;
                    // The initial pass (no round yet) never counts as converged.
                    if (chg_reg == 0 && rounds_reg != 0)
                    begin
                        conv_reg <= 1'b1; rdone_reg <= rounds_reg; state_reg <= S_FIN;
                    end
                    else if (iters_reg == 0)
                    begin
                        conv_reg <= 1'b0; rdone_reg <= rounds_reg; state_reg <= S_FIN;
                    end
                    else
                    begin
                        iters_reg <= iters_reg - 1'b1; state_reg <= S_DNEXT;
                    end
                end
                S_DNEXT:
                begin
                    if (ci_reg == k_reg)
                    begin
                        rounds_reg <= rounds_reg + 1'b1;
                        if (iters_reg == 0)
                        begin
                            conv_reg <= 1'b0; rdone_reg <= rounds_reg + 1'b1;
                            state_reg <= S_FIN;
                        end
                        else state_reg <= S_CLR;
                    end
                    else if (mc_reg[ci_reg[ClAw-1:0]] != 0) state_reg <= S_DIVX;
                    else ci_reg <= ci_reg + 1'b1;
                end
                S_DIVX:
                begin
                    if (ddone)
                    begin
                        cx_reg[ci_reg[ClAw-1:0]] <= dq[CoordW-1:0];
                        state_reg <= S_DIVY;
                    end
                end
                S_DIVY:
                begin
                    if (ddone)
                    begin
                        cy_reg[ci_reg[ClAw-1:0]] <= dq[CoordW-1:0];
                        ci_reg <= ci_reg + 1'b1;
                        state_reg <= S_DNEXT;
                    end
                end
                S_RDOUT:
                begin
                    if (q_reg.opcode == OP_WRITE) ;
                    else if (q_reg.opcode == OP_RDCEN)
                    begin
                        if (q_reg.index < 10'(MaxClusters))
                        begin
                            rsp_reg.out_x <= cx_reg[q_reg.index[ClAw-1:0]];
                            rsp_reg.out_y <= cy_reg[q_reg.index[ClAw-1:0]];
                        end
                        else rsp_reg.status <= ST_RANGE;
                    end
                    else if (q_reg.opcode == OP_RDASG)
                        rsp_reg.out_cluster <= 4'(asg_rd);
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    done_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign clearing = clr_reg;
    always_comb
    begin
        rsp = rsp_reg;
        rsp.out_rounds = rdone_reg;
        rsp.out_converged = conv_reg;
    end
endmodule

[sim/km2d_checker.sv]
`timescale 1ns / 100ps
// Checker for kmeans_clustering_2d: watches the request, response and register ports,
// predicts each response word and compares it field by field.
// Depends on km2d_pkg.
module km2d_checker
    import km2d_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  req_t        in_data,
    input  logic        out_valid,
    input  logic        out_ready,
    input  rsp_t        out_data,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          errors,
    output int          pending
);

    logic [10:0] npts;
    logic [4:0]  nclus;
    logic [15:0] iter_max;

    longint      px [MaxPoints];
    longint      py [MaxPoints];
    logic [3:0]  asg [MaxPoints];
    longint      cen_x [MaxClusters];
    longint      cen_y [MaxClusters];
    longint      acc_x [MaxClusters];
    longint      acc_y [MaxClusters];
    int          members [MaxClusters];
    logic [15:0] rounds_done;
    logic        conv_flag;

    rsp_t        expected_rsp [$];

    // Nearest centroid by exact squared distance, lower index wins ties.
    function automatic int nearest(int p, int k);
        longint dx, dy, d, best_d;
        int best;
        best = 0;
        best_d = -1;
        for (int c = 0; c < k; c++)
        begin
            dx = px[p] - cen_x[c];
            dy = py[p] - cen_y[c];
            d = dx * dx + dy * dy;
            if (best_d < 0 || d < best_d)
            begin
                best = c;
                best_d = d;
            end
        end
        return best;
    endfunction

    // Reassign all points, rebuild sums; returns number of changed assignments.
    function automatic int reassign(int n, int k);
        int c, changed;
        changed = 0;
        for (int j = 0; j < MaxClusters; j++)
        begin
            acc_x[j] = 0;
            acc_y[j] = 0;
            members[j] = 0;
        end
        for (int i = 0; i < n; i++)
        begin
            c = nearest(i, k);
            if (c != asg[i])
            begin
                asg[i] = c[3:0];
                changed++;
            end
            acc_x[c] += px[i];
            acc_y[c] += py[i];
            members[c]++;
        end
        return changed;
    endfunction

    function automatic logic [1:0] cluster_run();
        int n, k, iters, rounds, change;
        logic conv;
        n = npts;
        k = nclus;
        iters = iter_max;
        rounds = 0;
        conv = 1'b0;
        if (k == 0 || k > MaxClusters)
            return ST_COUNT;
        if (n > MaxPoints)
            return ST_RANGE;
        if (k > n)
            return ST_COUNT;
        for (int c = 0; c < k; c++)
        begin
            cen_x[c] = px[c];
            cen_y[c] = py[c];
        end
        change = reassign(n, k);
        change = 1;  // the first assignment never counts as converged
        forever
        begin
            if (change == 0)
            begin
                conv = 1'b1;
                break;
            end
            if (iters == 0)
                break;
            iters--;
            for (int c = 0; c < k; c++)
                if (members[c] != 0)
                begin
                    cen_x[c] = acc_x[c] / members[c];
                    cen_y[c] = acc_y[c] / members[c];
                end
            rounds++;
            if (iters == 0)
                break;
            change = reassign(n, k);
        end
        rounds_done = rounds[15:0];
        conv_flag = conv;
        return ST_OK;
    endfunction

    function automatic rsp_t predict_word(req_t w);
        rsp_t r;
        r = '0;
        case (w.opcode)
            OP_WRITE:
            begin
                px[w.index] = w.point_x;
                py[w.index] = w.point_y;
            end
            OP_RUN:
                r.status = cluster_run();
            OP_RDCEN:
                if (w.index < MaxClusters)
                begin
                    r.out_x = cen_x[w.index][15:0];
                    r.out_y = cen_y[w.index][15:0];
                end
                else
                    r.status = ST_RANGE;
            default:
                r.out_cluster = asg[w.index];
        endcase
        r.out_rounds = rounds_done;
        r.out_converged = conv_flag;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t exp_w;
        if (!rst_n)
        begin
            npts = 11'd1;
            nclus = 5'd1;
            iter_max = '0;
            for (int i = 0; i < MaxPoints; i++)
            begin
                px[i] = 0;
                py[i] = 0;
                asg[i] = '0;
            end
            for (int j = 0; j < MaxClusters; j++)
            begin
                cen_x[j] = 0;
                cen_y[j] = 0;
                acc_x[j] = 0;
                acc_y[j] = 0;
                members[j] = 0;
            end
            rounds_done = '0;
            conv_flag = 1'b0;
            expected_rsp.delete();
            errors = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_we)
                case (cfg_index)
                    REG_NPTS: npts = cfg_data[10:0];
                    REG_NCL:  nclus = cfg_data[4:0];
                    REG_ITER: iter_max = cfg_data;
                    default: ;
                endcase
            if (out_valid && out_ready)
            begin
                if (expected_rsp.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: unexpected word %p", $realtime, out_data);
                end
                else
                begin
                    exp_w = expected_rsp.pop_front();
                    if (out_data.out_x !== exp_w.out_x || out_data.out_y !== exp_w.out_y
                        || out_data.out_cluster !== exp_w.out_cluster
                        || out_data.out_rounds !== exp_w.out_rounds
                        || out_data.out_converged !== exp_w.out_converged
                        || out_data.status !== exp_w.status)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("%0t: mismatch exp %p got %p", $realtime, exp_w, out_data);
                    end
                end
            end
            if (in_valid && in_ready)
                expected_rsp.push_back(predict_word(in_data));
            pending = expected_rsp.size();
        end
    end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps
// Top of the kmeans_clustering_2d testbench: clock, reset, stimulus and verdict.
// Depends on km2d_pkg, km2d_if, km2d_checker and the block itself.
module tb_top;
    import km2d_pkg::*;

    localparam int WatchLimit = 500000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    int          errors;
    int          pending;
    int          send_idle;  // percent of cycles the sender holds back
    int          recv_idle;  // percent of cycles the receiver stalls
    int          quiet_cycles = 0;

    km2d_if #(.T(req_t)) req_ch (clk);
    km2d_if #(.T(rsp_t)) rsp_ch (clk);

    kmeans_clustering_2d i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (req_ch),
        .out_ch    (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    km2d_checker i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req_ch.valid),
        .in_ready  (req_ch.ready),
        .in_data   (req_ch.data),
        .out_valid (rsp_ch.valid),
        .out_ready (rsp_ch.ready),
        .out_data  (rsp_ch.data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    initial
        clk = 1'b0;
    always #6 clk = ~clk;

    // Receiver: stall at random, one decision per edge.
    always @(posedge clk)
        rsp_ch.ready <= ($urandom_range(99) >= recv_idle);

    // Watchdog: counts edges with no word moving on either channel.
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WatchLimit)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    // Send one request word; valid stays high into the next word unless we idle.
    task automatic send_word(input logic [1:0] op, input int idx,
                             input logic [15:0] x, input logic [15:0] y);
        req_t w;
        w.opcode = op;
        w.index = idx[9:0];
        w.point_x = x;
        w.point_y = y;
        while ($urandom_range(99) < send_idle)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data <= w;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    // Wait until every expected word is back, plus margin for the read pipeline.
    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Registers are only touched with the block idle.
    task automatic set_regs(input int n, input int k, input int it);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= REG_NPTS;
        cfg_data <= n[15:0];
        @(posedge clk);
        cfg_index <= REG_NCL;
        cfg_data <= k[15:0];
        @(posedge clk);
        cfg_index <= REG_ITER;
        cfg_data <= it[15:0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Clustered coordinates so that runs take several rounds; sometimes full range.
    function automatic logic [15:0] coord(input int center);
        int v;
        if ($urandom_range(7) == 0)
            return 16'($urandom());
        v = center + $signed($urandom_range(4000)) - 2000;
        return v[15:0];
    endfunction

    initial
    begin
        int n, k, it, op, center;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        send_idle = 11;
        recv_idle = 61;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Runs may only use written points, so points 0 to 39
        // get values up front, corners first.
        send_word(OP_RDCEN, 0, 16'h0, 16'h0);
        send_word(OP_WRITE, 0, 16'h7fff, 16'h7fff);
        send_word(OP_WRITE, 1, 16'h8000, 16'h8000);
        send_word(OP_WRITE, 2, 16'h7fff, 16'h8000);
        send_word(OP_WRITE, 3, 16'h8000, 16'h7fff);
        send_word(OP_RUN, 0, 16'h0, 16'h0);  // reset config: one point, one cluster
        for (int i = 4; i < 40; i++)
            send_word(OP_WRITE, i, 16'($urandom()), 16'($urandom()));
        set_regs(4, 4, 65535);        // each point its own cluster, converges at once
        send_word(OP_RUN, 0, 16'h0, 16'h0);
        send_word(OP_RDCEN, 1, 16'h0, 16'h0);
        send_word(OP_RDASG, 3, 16'h0, 16'h0);
        set_regs(40, 16, 1);          // all sixteen clusters
        send_word(OP_RUN, 0, 16'h0, 16'h0);
        send_word(OP_RDCEN, 15, 16'h0, 16'h0);
        send_word(OP_RDCEN, 16, 16'h0, 16'h0);   // cluster index out of range
        send_word(OP_RDASG, 1023, 16'h0, 16'h0);
        set_regs(40, 2, 0);           // zero iterations: initial assignment only
        send_word(OP_RUN, 0, 16'h0, 16'h0);
        set_regs(1024, 0, 3);         // zero clusters
        send_word(OP_RUN, 0, 16'h0, 16'h0);
        set_regs(1024, 31, 3);        // too many clusters
        send_word(OP_RUN, 0, 16'h0, 16'h0);
        set_regs(2047, 2, 3);         // too many points
        send_word(OP_RUN, 0, 16'h0, 16'h0);
        set_regs(0, 1, 3);            // no points, so k above n
        send_word(OP_RUN, 0, 16'h0, 16'h0);
        set_regs(3, 4, 3);            // k above n
        send_word(OP_RUN, 0, 16'h0, 16'h0);
        send_word(OP_RDCEN, 1023, 16'h0, 16'h0);

        // Random part: three idle patterns, each with a few register settings.
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle = (phase == 0) ? 11 : (phase == 1) ? 61 : 0;
            recv_idle = (phase == 0) ? 61 : (phase == 1) ? 11 : 0;
            for (int sub = 0; sub < 3; sub++)
            begin
                n = $urandom_range(1, 40);
                k = $urandom_range(1, (n < 16) ? n : 16);
                it = $urandom_range(0, 20);
                if ($urandom_range(9) == 0)
                    k = $urandom_range(0, 31);  // often a bad count
                set_regs(n, k, it);
                center = $signed($urandom_range(40000)) - 20000;
                for (int j = 0; j < 5; j++)
                begin
                    op = $urandom_range(9);
                    if (op < 5)
                        send_word(OP_WRITE, (op == 0) ? $urandom_range(1023)
                                                      : $urandom_range(n - 1),
                                  coord(center + 8000 * (j % 3)), coord(center - 6000 * (j % 2)));
                    else if (op < 7)
                        send_word(OP_RUN, $urandom_range(1023), 16'($urandom()),
                                  16'($urandom()));
                    else if (op < 9)
                        send_word(OP_RDCEN, ($urandom_range(3) == 0) ? $urandom_range(1023)
                                                                     : $urandom_range(15),
                                  16'($urandom()), 16'($urandom()));
                    else
                        send_word(OP_RDASG, $urandom_range(1023), 16'($urandom()),
                                  16'($urandom()));
                end
                send_word(OP_RUN, 0, 16'h0, 16'h0);
            end
        end

        drain();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

[files.f]
rtl/core/km2d_pkg.sv
rtl/core/km2d_if.sv
rtl/core/km2d_div.sv
rtl/core/km2d_core.sv
rtl/core/kmeans_clustering_2d.sv
sim/km2d_checker.sv
sim/tb_top.sv
